// ----- rtl/fpba_pkg.sv -----
//------------------------------------------------------------------------------
// fpba_pkg
// Shared types and constants of the fixed predictor block analyzer.
//------------------------------------------------------------------------------
package fpba_pkg;

    localparam int MaxBlock  = 4096;
    localparam int CntW      = $clog2(MaxBlock + 1);
    localparam int SumW      = 48;
    localparam int RootW     = SumW / 2;
    localparam int QDepth    = 2;

    // one finished block handed from front to back
    typedef struct packed {
        logic            short_blk;
        logic            pred;
        logic [17:0]     peak;
        logic [SumW-1:0] err;
        logic [CntW-1:0] n1;
        logic            too_long;
    } t_job;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_SQRT,
        ST_OUT
    } t_state;

endpackage

// ----- rtl/fixed_predictor_block_analyzer_top.sv -----
//------------------------------------------------------------------------------
// fixed_predictor_block_analyzer_top
// Picks the fixed order-1 or order-2 predictor for a block of samples.
//------------------------------------------------------------------------------
// Samples enter one per cycle; squares are registered and accumulated in the
// following cycle. After each last sample the input pauses while the block's
// statistics are handed to a two-entry job queue, and longer while that
// queue is full. A back end divides serially and then takes the root
// serially; it takes a new block only once the result of the last one has
// been taken.
module fixed_predictor_block_analyzer_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // sample
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata    // predictor, peak residual, rms residual, too_long
);

    fpba_pkg::t_job w_fj, w_bj;
    logic w_fv, w_fr, w_bv, w_br;

    fpba_front u_front (
        .i_clk, .i_rst_n, .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_sample(s_axis_tdata), .i_last(s_axis_tlast),
        .o_job_valid(w_fv), .i_job_ready(w_fr), .o_job(w_fj)
    );

    fpba_queue u_queue (
        .i_clk, .i_rst_n, .i_valid(w_fv), .o_ready(w_fr), .i_job(w_fj),
        .o_valid(w_bv), .i_ready(w_br), .o_job(w_bj)
    );

    fpba_back u_back (
        .i_clk, .i_rst_n, .i_valid(w_bv), .o_ready(w_br), .i_job(w_bj),
        .o_tvalid(m_axis_tvalid), .i_tready(m_axis_tready), .o_tdata(m_axis_tdata)
    );

endmodule

// ----- rtl/fpba_front.sv -----
//------------------------------------------------------------------------------
// fpba_front
// Accepts samples, accumulates residual statistics, emits one job per block.
//------------------------------------------------------------------------------
module fpba_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [15:0]      i_sample,
    input  logic             i_last,
    output logic             o_job_valid,
    input  logic             i_job_ready,
    output fpba_pkg::t_job   o_job
);

    logic signed [15:0]            r_prev, r_prev2;
    logic [fpba_pkg::CntW-1:0]     r_cnt;
    logic [fpba_pkg::SumW-1:0]     r_sum1, r_sum2;
    logic [16:0]                   r_pk1;
    logic [17:0]                   r_pk2;
    logic                          r_ovf;
    // pipeline stage: squares registered before accumulation
    logic                          r_sv, r_slast;
    logic [33:0]                   r_sq1, r_sq2;
    logic                          r_jv;
    fpba_pkg::t_job                r_job;

    logic signed [17:0] w_d1, w_d2;
    logic [16:0]        w_a1;
    logic [17:0]        w_a2;
    logic               w_acc, w_use;
    logic [fpba_pkg::SumW:0] w_s1, w_s2;
    logic [fpba_pkg::SumW-1:0] w_f1, w_f2;

    assign o_ready = !r_jv && !r_slast;
    assign w_acc   = i_valid && o_ready;
    assign w_use   = (r_cnt != '0) && (r_cnt < fpba_pkg::CntW'(fpba_pkg::MaxBlock));
    assign w_d1 = 18'(signed'(i_sample)) - 18'(r_prev);
    assign w_d2 = 18'(signed'(i_sample)) - (18'(r_prev) <<< 1) + 18'(r_prev2);
    assign w_a1 = w_d1[17] ? 17'(-w_d1) : w_d1[16:0];
    assign w_a2 = w_d2[17] ? 18'(-w_d2) : w_d2;
    assign w_s1 = {1'b0, r_sum1} + (fpba_pkg::SumW+1)'(r_sv ? r_sq1 : 34'd0);
    assign w_s2 = {1'b0, r_sum2} + (fpba_pkg::SumW+1)'(r_sv ? r_sq2 : 34'd0);
    assign w_f1 = w_s1[fpba_pkg::SumW] ? '1 : w_s1[fpba_pkg::SumW-1:0];
    assign w_f2 = w_s2[fpba_pkg::SumW] ? '1 : w_s2[fpba_pkg::SumW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0; r_sum1 <= '0; r_sum2 <= '0; r_pk1 <= '0; r_pk2 <= '0;
            r_ovf <= 1'b0; r_sv <= 1'b0; r_slast <= 1'b0; r_jv <= 1'b0;
            r_prev <= '0; r_prev2 <= '0;
        end else begin
            if (r_jv && i_job_ready) r_jv <= 1'b0;
            r_sv    <= w_acc && w_use;
            r_slast <= w_acc && i_last;
            r_sq1   <= 34'(w_a1) * 34'(w_a1);
            r_sq2   <= 34'(w_a2) * 34'(w_a2);
            if (r_slast) begin
                r_jv <= 1'b1;
                r_job.short_blk <= r_cnt < fpba_pkg::CntW'(2);
                r_job.pred      <= !(w_f2 > w_f1);
                r_job.peak      <= (w_f2 > w_f1) ? 18'(r_pk1) : r_pk2;
                r_job.err       <= (w_f2 > w_f1) ? w_f1 : w_f2;
                r_job.n1        <= r_cnt - 1'b1;
                r_job.too_long  <= r_ovf;
                r_cnt <= '0; r_sum1 <= '0; r_sum2 <= '0; r_pk1 <= '0; r_pk2 <= '0;
                r_ovf <= 1'b0;
            end else begin
                r_sum1 <= w_f1;
                r_sum2 <= w_f2;
                if (w_acc) begin
                    if (r_cnt == '0) begin
                        r_prev <= i_sample; r_prev2 <= i_sample;
                        r_cnt <= fpba_pkg::CntW'(1);
                    end else if (w_use) begin
                        if (w_a1 > r_pk1) r_pk1 <= w_a1;
                        if (w_a2 > r_pk2) r_pk2 <= w_a2;
                        r_prev2 <= r_prev; r_prev <= i_sample; r_cnt <= r_cnt + 1'b1;
                    end else begin
                        r_ovf <= 1'b1;
                    end
                end
            end
        end
    end

    assign o_job_valid = r_jv;
    assign o_job       = r_job;

endmodule

// ----- rtl/fpba_queue.sv -----
//------------------------------------------------------------------------------
// fpba_queue
// Short job FIFO between the front and back ends.
//------------------------------------------------------------------------------
module fpba_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  fpba_pkg::t_job i_job,
    output logic           o_valid,
    input  logic           i_ready,
    output fpba_pkg::t_job o_job
);

    fpba_pkg::t_job r_mem [fpba_pkg::QDepth];
    logic [$clog2(fpba_pkg::QDepth)-1:0] r_wp, r_rp;
    logic [$clog2(fpba_pkg::QDepth+1)-1:0] r_n;
    logic w_wr, w_rd;

    assign o_ready = r_n != ($clog2(fpba_pkg::QDepth+1))'(fpba_pkg::QDepth);
    assign o_valid = r_n != '0;
    assign w_wr = i_valid && o_ready;
    assign w_rd = o_valid && i_ready;
    assign o_job = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_wr) r_mem[r_wp] <= i_job;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_n <= '0;
        end else begin
            if (w_wr) r_wp <= r_wp + 1'b1;
            if (w_rd) r_rp <= r_rp + 1'b1;
            if (w_wr && !w_rd) r_n <= r_n + 1'b1;
            else if (w_rd && !w_wr) r_n <= r_n - 1'b1;
        end
    end

endmodule

// ----- rtl/fpba_back.sv -----
//------------------------------------------------------------------------------
// fpba_back
// Serial divide of the error sum by n-1, then serial integer square root; short blocks skip both.
//------------------------------------------------------------------------------
module fpba_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  fpba_pkg::t_job i_job,
    output logic           o_tvalid,
    input  logic           i_tready,
    output logic [39:0]    o_tdata
);

    localparam int SumW = fpba_pkg::SumW;
    localparam int RW   = fpba_pkg::RootW;

    fpba_pkg::t_state r_st, n_st;
    fpba_pkg::t_job   r_job;
    logic [SumW-1:0]  r_q;
    logic [fpba_pkg::CntW-1:0] r_rem;
    logic [5:0]       r_i;
    logic [RW-1:0]    r_rx;
    logic [RW-1:0]    r_root;

    logic [fpba_pkg::CntW:0] w_tr;
    logic             w_ge;
    logic [RW+1:0]    w_t;
    logic [RW+1:0]    w_rt;

    assign w_tr = {r_rem, r_q[SumW-1]};
    assign w_ge = w_tr >= (fpba_pkg::CntW+1)'(r_job.n1);
    assign w_t  = {r_rx, r_q[SumW-1:SumW-2]};
    assign w_rt = {r_root, 2'b01};

    always_comb begin
        n_st = r_st;
        case (r_st)
            fpba_pkg::ST_IDLE: if (i_valid) n_st = i_job.short_blk ? fpba_pkg::ST_OUT
                                                                   : fpba_pkg::ST_DIV;
            fpba_pkg::ST_DIV:  if (r_i == 6'(SumW-1)) n_st = fpba_pkg::ST_SQRT;
            fpba_pkg::ST_SQRT: if (r_i == 6'(RW-1)) n_st = fpba_pkg::ST_OUT;
            fpba_pkg::ST_OUT:  if (i_tready) n_st = fpba_pkg::ST_IDLE;
            default:           n_st = fpba_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_ready  = r_st == fpba_pkg::ST_IDLE;
        o_tvalid = r_st == fpba_pkg::ST_OUT;
        o_tdata  = '0;
        if (!r_job.short_blk)
            o_tdata = {4'd0, r_job.too_long, r_root[16:0], r_job.peak[16:0], r_job.pred};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= fpba_pkg::ST_IDLE;
        end else begin
            r_st <= n_st;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_st)
            fpba_pkg::ST_IDLE: begin
                r_job <= i_job; r_q <= i_job.err; r_rem <= '0; r_i <= '0;
            end
            fpba_pkg::ST_DIV: begin
                r_q <= {r_q[SumW-2:0], w_ge};
                r_rem <= w_ge ? fpba_pkg::CntW'(w_tr - (fpba_pkg::CntW+1)'(r_job.n1))
                              : fpba_pkg::CntW'(w_tr);
                r_i <= (r_i == 6'(SumW-1)) ? '0 : r_i + 1'b1;
                r_rx <= '0; r_root <= '0;
            end
            fpba_pkg::ST_SQRT: begin
                // restoring root: two radicand bits in per step
                if (w_t >= w_rt) begin
                    r_rx <= RW'(w_t - w_rt);
                    r_root <= {r_root[RW-2:0], 1'b1};
                end else begin
                    r_rx <= RW'(w_t);
                    r_root <= {r_root[RW-2:0], 1'b0};
                end
                r_q <= {r_q[SumW-3:0], 2'b00};
                r_i <= r_i + 1'b1;
            end
            default: ;
        endcase
    end

endmodule

// ----- rtl/fpba_checker.sv -----
//------------------------------------------------------------------------------
// fpba_checker
// Port-level checks of the analyzer.
//------------------------------------------------------------------------------
module fpba_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped");
    a_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[39:36] == 4'd0)
        else $error("pad bits set");
    a_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready |=> !m_axis_tvalid)
        else $error("results back to back");

endmodule

bind fixed_predictor_block_analyzer_top fpba_checker u_chk (
    .i_clk, .i_rst_n, .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
);
